// ===== src/demc_pkg.sv =====
// Package for the double exponent/mantissa converter.
// Holds the item types, sentinels and shared helper functions; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package demc_pkg;

   typedef struct packed {
      logic        op;
      logic [63:0] value_bits;
      logic signed [31:0] exponent_in;
      logic signed [63:0] mantissa_in;
   } req_type;

   typedef struct packed {
      logic signed [11:0] exponent_out;
      logic signed [63:0] mantissa_out;
      logic [63:0]        value_bits_out;
   } rsp_type;

   localparam logic [63:0] SENT_NEG_INF = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] SENT_POS_INF = 64'hefff_ffff_ffff_ffff;
   localparam logic [63:0] SENT_NAN     = 64'hdfff_ffff_ffff_ffff;
   localparam logic [63:0] QNAN_BITS    = 64'h7ff8_0000_0000_0000;
   localparam logic [63:0] INF_BITS     = 64'h7ff0_0000_0000_0000;
   localparam logic [31:0] EXP_SPECIAL  = 32'hffff_ffff;
   localparam logic        OP_ENCODE    = 1'b0;

   // Position of the highest set bit of a 64-bit word (priority encoder).
   function automatic logic [5:0] top_bit(input logic [63:0] v);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

   // Right shift by s (1..63) with round to nearest, ties to even.
   function automatic logic [63:0] shr_round(input logic [63:0] v, input logic [5:0] s);
      logic [63:0] keep;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] mask;
      keep = v >> s;
      mask = (64'd1 << s) - 64'd1;
      rem  = v & mask;
      half = 64'd1 << (s - 6'd1);
      if (rem > half || (rem == half && keep[0])) begin
         keep = keep + 64'd1;
      end
      return keep;
   endfunction

endpackage
`default_nettype wire

// ===== src/double_exponent_mantissa_converter.sv =====
// Converts between a binary64 pattern and a signed exponent and mantissa.
// The req_ channel takes an item with op 0 (encode value_bits) or op 1
// (decode exponent_in and mantissa_in); the rsp_ channel gives one item
// per request, with the fields of the other mode zero.
// Encode: mantissa is the frexp fraction times 2^62; infinities and NaN
// give exponent -1 with sentinel mantissas. Decode rounds to nearest even
// twice (to 53 bits, then into the subnormal grid) and saturates to inf.
// Pipeline: the req item passes through the five register stages of the
// pipeline (special/magnitude, leading one, first rounding, exponent,
// packing), the first of which loads at the accepting edge. Throughput is
// one item per cycle while the receiver does not stall.
// The pipeline advances as a whole whenever the result register is empty
// or being taken, so a stalled receiver freezes every stage and nothing is
// lost or repeated. Reset clears all stage valid bits; it depends on
// demc_pkg, demc_norm and demc_pack.
`timescale 1ns / 1ps
`default_nettype none
module double_exponent_mantissa_converter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire demc_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output demc_pkg::rsp_type      rsp_item
);

   logic advance;
   logic s2_valid, s2_op, s2_done, s2_sign;
   logic [63:0] s2_word, s2_mag;
   logic [5:0]  s2_top;
   logic signed [33:0] s2_exp;

   // Whole-pipeline enable.
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   demc_norm u_norm (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_valid), .in_item(req_item),
      .s2_valid_ff(s2_valid), .s2_op_ff(s2_op), .s2_done_ff(s2_done),
      .s2_word_ff(s2_word), .s2_mag_ff(s2_mag), .s2_top_ff(s2_top),
      .s2_sign_ff(s2_sign), .s2_exp_ff(s2_exp)
   );

   demc_pack u_pack (
      .clock(clock), .reset(reset), .advance(advance),
      .s2_valid_ff(s2_valid), .s2_op_ff(s2_op), .s2_done_ff(s2_done),
      .s2_word_ff(s2_word), .s2_mag_ff(s2_mag), .s2_top_ff(s2_top),
      .s2_sign_ff(s2_sign), .s2_exp_ff(s2_exp),
      .out_valid(rsp_valid), .out_item(rsp_item)
   );

endmodule
`default_nettype wire

// ===== src/demc_norm.sv =====
// Stages 1 and 2 of the converter: special detection, magnitude and leading-one search.
// Depends on demc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module demc_norm (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             in_valid,
   input  wire demc_pkg::req_type in_item,
   output logic                  s2_valid_ff,
   output logic                  s2_op_ff,
   output logic                  s2_done_ff,
   output logic [63:0]           s2_word_ff,
   output logic [63:0]           s2_mag_ff,
   output logic [5:0]            s2_top_ff,
   output logic                  s2_sign_ff,
   output logic signed [33:0]    s2_exp_ff
);

   // Stage 1 registers.
   logic        s1_valid_ff;
   logic        s1_op_ff;
   logic        s1_done_ff;
   logic [63:0] s1_word_ff, s1_word_in;
   logic [63:0] s1_mag_ff, s1_mag_in;
   logic        s1_sign_ff;
   logic signed [33:0] s1_exp_ff, s1_exp_in;
   logic        s1_done_in;
   logic        neg;
   logic [10:0] e;
   logic [51:0] f;

   // Stage 1: classify the item and form the unsigned magnitude.
   always_comb begin
      s1_done_in = 1'b0;
      s1_word_in = 64'd0;
      s1_mag_in  = 64'd0;
      s1_exp_in  = 34'sd0;
      neg = in_item.value_bits[63];
      e   = in_item.value_bits[62:52];
      f   = in_item.value_bits[51:0];
      if (in_item.op == demc_pkg::OP_ENCODE) begin
         if (e == 11'h7ff) begin
            s1_done_in = 1'b1;
            s1_word_in = (f != 52'd0) ? demc_pkg::SENT_NAN :
                         (neg ? demc_pkg::SENT_NEG_INF : demc_pkg::SENT_POS_INF);
         end else if (e == 11'd0 && f == 52'd0) begin
            s1_done_in = 1'b1;
         end else if (e == 11'd0) begin
            s1_mag_in = {12'd0, f};
            s1_exp_in = -34'sd1073;
         end else begin
            s1_mag_in = {2'b01, f, 10'd0} >> 1;
            s1_exp_in = 34'(signed'({23'd0, e})) - 34'sd1022;
         end
      end else begin
         s1_exp_in = 34'(in_item.exponent_in);
         if (in_item.exponent_in == demc_pkg::EXP_SPECIAL &&
             in_item.mantissa_in == demc_pkg::SENT_NEG_INF) begin
            s1_done_in = 1'b1;
            s1_word_in = {1'b1, 63'd0} | demc_pkg::INF_BITS;
         end else if (in_item.exponent_in == demc_pkg::EXP_SPECIAL &&
                      in_item.mantissa_in == demc_pkg::SENT_POS_INF) begin
            s1_done_in = 1'b1;
            s1_word_in = demc_pkg::INF_BITS;
         end else if (in_item.exponent_in == demc_pkg::EXP_SPECIAL &&
                      in_item.mantissa_in == demc_pkg::SENT_NAN) begin
            s1_done_in = 1'b1;
            s1_word_in = demc_pkg::QNAN_BITS;
         end else if (in_item.mantissa_in == 64'sd0) begin
            s1_done_in = 1'b1;
         end else begin
            s1_mag_in = in_item.mantissa_in[63] ? (64'd0 - in_item.mantissa_in)
                                                : in_item.mantissa_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
      if (advance) begin
         s1_op_ff   <= in_item.op;
         s1_done_ff <= s1_done_in;
         s1_word_ff <= s1_word_in;
         s1_mag_ff  <= s1_mag_in;
         s1_sign_ff <= (in_item.op == demc_pkg::OP_ENCODE) ? in_item.value_bits[63]
                                                           : in_item.mantissa_in[63];
         s1_exp_ff  <= s1_exp_in;
      end
   end

   // Stage 2: leading-one search on the magnitude.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_op_ff   <= s1_op_ff;
         s2_done_ff <= s1_done_ff;
         s2_word_ff <= s1_word_ff;
         s2_mag_ff  <= s1_mag_ff;
         s2_top_ff  <= demc_pkg::top_bit(s1_mag_ff);
         s2_sign_ff <= s1_sign_ff;
         s2_exp_ff  <= s1_exp_ff;
      end
   end

endmodule
`default_nettype wire

// ===== src/demc_pack.sv =====
// Stages 3 to 5 of the converter: first rounding, exponent, packing.
// Depends on demc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module demc_pack (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             s2_valid_ff,
   input  wire logic             s2_op_ff,
   input  wire logic             s2_done_ff,
   input  wire logic [63:0]      s2_word_ff,
   input  wire logic [63:0]      s2_mag_ff,
   input  wire logic [5:0]       s2_top_ff,
   input  wire logic             s2_sign_ff,
   input  wire logic signed [33:0] s2_exp_ff,
   output logic                  out_valid,
   output demc_pkg::rsp_type     out_item
);

   // Stage 3: encode normalization shift, decode rounding to 53 bits.
   logic        s3_valid_ff, s3_op_ff, s3_done_ff, s3_sign_ff;
   logic [63:0] s3_word_ff, s3_keep_ff, s3_keep_in;
   logic signed [33:0] s3_exp_ff, s3_exp_in;
   logic [5:0]  shift;
   logic [63:0] rnd;

   always_comb begin
      shift = 6'd0;
      rnd   = 64'd0;
      s3_keep_in = s2_mag_ff;
      s3_exp_in  = s2_exp_ff;
      if (s2_op_ff == demc_pkg::OP_ENCODE) begin
         // Only subnormals need shifting and an exponent adjustment; normals are already aligned.
         s3_keep_in = s2_mag_ff << (6'd61 - s2_top_ff);
         if (s2_exp_ff == -34'sd1073) begin
            s3_exp_in = s2_exp_ff + 34'(s2_top_ff);
         end
      end else if (s2_top_ff > 6'd52) begin
         shift = s2_top_ff - 6'd52;
         rnd   = demc_pkg::shr_round(s2_mag_ff, shift);
         if (rnd[53]) begin
            s3_keep_in = rnd >> 1;
            s3_exp_in  = s2_exp_ff + 34'(shift) + 34'sd1 - 34'sd62;
         end else begin
            s3_keep_in = rnd;
            s3_exp_in  = s2_exp_ff + 34'(shift) - 34'sd62;
         end
      end else begin
         s3_exp_in = s2_exp_ff - 34'sd62;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_op_ff   <= s2_op_ff;
         s3_done_ff <= s2_done_ff;
         s3_sign_ff <= s2_sign_ff;
         s3_word_ff <= s2_word_ff;
         s3_keep_ff <= s3_keep_in;
         s3_exp_ff  <= s3_exp_in;
      end
   end

   // Stage 4: biased exponent and subnormal shift amount for decode.
   logic        s4_valid_ff, s4_op_ff, s4_done_ff, s4_sign_ff;
   logic [63:0] s4_word_ff, s4_keep_ff;
   logic signed [33:0] s4_exp_ff, s4_biased_ff, s4_k_ff;
   logic [5:0]  s4_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_op_ff     <= s3_op_ff;
         s4_done_ff   <= s3_done_ff;
         s4_sign_ff   <= s3_sign_ff;
         s4_word_ff   <= s3_word_ff;
         s4_keep_ff   <= s3_keep_ff;
         s4_exp_ff    <= s3_exp_ff;
         s4_q_ff      <= demc_pkg::top_bit(s3_keep_ff);
         s4_biased_ff <= s3_exp_ff + 34'(demc_pkg::top_bit(s3_keep_ff)) + 34'sd1023;
         s4_k_ff      <= s3_exp_ff + 34'sd1074;
      end
   end

   // Stage 5: final packing into the result item.
   demc_pkg::rsp_type res_in;
   logic [63:0] m;
   logic [63:0] sub;

   always_comb begin
      res_in = '0;
      m   = 64'd0;
      sub = 64'd0;
      if (s4_op_ff == demc_pkg::OP_ENCODE) begin
         if (s4_done_ff) begin
            res_in.exponent_out = (s4_word_ff != 64'd0) ? -12'sd1 : 12'sd0;
            res_in.mantissa_out = s4_word_ff;
         end else begin
            res_in.exponent_out = s4_exp_ff[11:0];
            res_in.mantissa_out = s4_sign_ff ? (64'd0 - s4_keep_ff) : s4_keep_ff;
         end
      end else if (s4_done_ff) begin
         res_in.value_bits_out = s4_word_ff;
      end else if (s4_biased_ff >= 34'sd2047) begin
         res_in.value_bits_out = {s4_sign_ff, 63'd0} | demc_pkg::INF_BITS;
      end else if (s4_biased_ff >= 34'sd1) begin
         m = s4_keep_ff << (6'd52 - s4_q_ff);
         res_in.value_bits_out = {s4_sign_ff, s4_biased_ff[10:0], m[51:0]};
      end else begin
         // Gradual underflow; a carry into bit 52 gives the least normal.
         if (s4_k_ff >= 34'sd0) begin
            sub = s4_keep_ff << s4_k_ff[5:0];
         end else if (s4_k_ff <= -34'sd55) begin
            sub = 64'd0;
         end else begin
            sub = demc_pkg::shr_round(s4_keep_ff, 6'(-s4_k_ff));
         end
         res_in.value_bits_out = {s4_sign_ff, 63'd0} | sub;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (advance) begin
         out_valid <= s4_valid_ff;
      end
      if (advance) begin
         out_item <= res_in;
      end
   end

endmodule
`default_nettype wire
